// ===== rtl/core/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// mcr_pkg: shared types and constants for the midpoint circle rasterizer
// Widths, decision-update constants, opcodes, register indexes and the job
// record that travels from the front end to the pixel back end.
// ----------------------------------------------------------------------------
package mcr_pkg;

    // Field widths fixed by the interface
    localparam int RAD_W    = 10;
    localparam int CTR_W    = 11;
    localparam int ORG_W    = 11;
    localparam int PIX_W    = 13;
    localparam int OCT_W    = 3;
    localparam int DEC_W    = 16;
    localparam int CFG_IDX_W = 1;

    // Radius precision; the point registers carry one extra sign bit
    localparam int RADIUS_BITS = 10;
    localparam int PT_W        = RADIUS_BITS + 1;
    localparam logic [RAD_W-1:0] RAD_MASK = RAD_W'((64'd1 << RADIUS_BITS) - 64'd1);

    // Decision variable constants
    localparam logic [DEC_W-1:0] DEC_INIT_OFS  = DEC_W'(3);
    localparam logic [DEC_W-1:0] DEC_STEP_DIAG = DEC_W'(10);
    localparam logic [DEC_W-1:0] DEC_STEP_AXIS = DEC_W'(6);

    // Origin reset value
    localparam logic [ORG_W-1:0] ORIGIN_RESET = ORG_W'(300);

    // Opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = CFG_IDX_W'(1);

    // Job queue depth (at least 2)
    localparam int JOBQ_DEPTH = 2;

    // One iteration's worth of work for the back end
    typedef struct packed {
        logic signed [PIX_W-1:0] scx;
        logic signed [PIX_W-1:0] scy;
        logic signed [PT_W-1:0]  pa;
        logic signed [PT_W-1:0]  pb;
        logic                    done;
    } job_t;

endpackage

// ===== rtl/core/mcr_front.sv =====
// ----------------------------------------------------------------------------
// mcr_front: item intake and midpoint iteration
// Accepts start/step items, keeps the walk state and decision variable, and
// queues one job per emitting item for the pixel back end.
// ----------------------------------------------------------------------------
module mcr_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    input  logic                                  opcode,
    input  logic        [mcr_pkg::RAD_W-1:0]      radius,
    input  logic signed [mcr_pkg::CTR_W-1:0]      centre_x,
    input  logic signed [mcr_pkg::CTR_W-1:0]      centre_y,
    input  logic        [mcr_pkg::ORG_W-1:0]      origin_x,
    input  logic        [mcr_pkg::ORG_W-1:0]      origin_y,
    input  logic                                  q_full,
    output logic                                  q_push,
    output mcr_pkg::job_t                         q_wdata,
    output logic                                  active
);
    import mcr_pkg::*;

    logic signed [PT_W-1:0]  point_x_reg, point_x_next;
    logic signed [PT_W-1:0]  point_y_reg, point_y_next;
    logic signed [DEC_W-1:0] decision_reg, decision_next;
    logic signed [PIX_W-1:0] scx_reg, scx_next;
    logic signed [PIX_W-1:0] scy_reg, scy_next;
    logic                    active_reg, active_next;

    logic                    accept;
    logic                    is_start;
    logic signed [PT_W-1:0]  r_pt;
    logic signed [PT_W-1:0]  base_a, base_b;
    logic signed [DEC_W-1:0] base_d;
    logic signed [PIX_W-1:0] base_scx, base_scy;
    logic signed [PT_W-1:0]  new_a, new_b;
    logic signed [DEC_W-1:0] new_d;
    logic signed [DEC_W-1:0] a4, b4;
    logic                    done;

    assign accept   = push && !q_full;
    assign is_start = (opcode == OP_START);
    assign r_pt     = PT_W'(radius & RAD_MASK);

    always_comb
    begin
        if (is_start)
        begin
            base_a   = '0;
            base_b   = r_pt;
            base_d   = DEC_W'({r_pt, 1'b0}) - DEC_INIT_OFS;
            base_scx = $signed(PIX_W'(origin_x)) + PIX_W'(centre_x);
            base_scy = $signed(PIX_W'(origin_y)) - PIX_W'(centre_y);
        end
        else
        begin
            base_a   = point_x_reg;
            base_b   = point_y_reg;
            base_d   = decision_reg;
            base_scx = scx_reg;
            base_scy = scy_reg;
        end

        // one midpoint step
        new_b = base_d[DEC_W-1] ? base_b - PT_W'(1) : base_b;
        new_a = base_a + PT_W'(1);
        a4    = DEC_W'(base_a) <<< 2;
        b4    = DEC_W'(new_b) <<< 2;
        if (base_d[DEC_W-1])
            new_d = base_d - DEC_STEP_DIAG - a4 + b4;
        else
            new_d = base_d - DEC_STEP_AXIS - a4;
        done = ($signed((PT_W+1)'(new_a)) > $signed((PT_W+1)'(new_b)));

        q_push        = accept && (is_start || active_reg);
        q_wdata.scx   = base_scx;
        q_wdata.scy   = base_scy;
        q_wdata.pa    = base_a;
        q_wdata.pb    = base_b;
        q_wdata.done  = done;

        point_x_next  = point_x_reg;
        point_y_next  = point_y_reg;
        decision_next = decision_reg;
        scx_next      = scx_reg;
        scy_next      = scy_reg;
        active_next   = active_reg;
        if (q_push)
        begin
            point_x_next  = new_a;
            point_y_next  = new_b;
            decision_next = new_d;
            scx_next      = base_scx;
            scy_next      = base_scy;
            active_next   = !done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_x_reg  <= '0;
            point_y_reg  <= '0;
            decision_reg <= '0;
            scx_reg      <= '0;
            scy_reg      <= '0;
            active_reg   <= 1'b0;
        end
        else
        begin
            point_x_reg  <= point_x_next;
            point_y_reg  <= point_y_next;
            decision_reg <= decision_next;
            scx_reg      <= scx_next;
            scy_reg      <= scy_next;
            active_reg   <= active_next;
        end
    end

    assign active = active_reg;

endmodule

// ===== rtl/core/mcr_job_fifo.sv =====
// ----------------------------------------------------------------------------
// mcr_job_fifo: short job queue between front end and back end
// Register-based FIFO of JOBQ_DEPTH entries, show-ahead read.
// ----------------------------------------------------------------------------
module mcr_job_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mcr_pkg::job_t  wdata,
    output logic           full,
    input  logic           pop,
    output mcr_pkg::job_t  rdata,
    output logic           empty
);
    import mcr_pkg::*;

    localparam int PTR_W = $clog2(JOBQ_DEPTH);
    localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(JOBQ_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(JOBQ_DEPTH);

    job_t             mem [JOBQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/mcr_back.sv =====
// ----------------------------------------------------------------------------
// mcr_back: eight-way pixel sequencer
// Walks the octant counter over one job, mirrors the point, places it around
// the screen centre, one pixel per cycle into the output register while free.
// ----------------------------------------------------------------------------
module mcr_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mcr_pkg::job_t                     q_rdata,
    input  logic                              q_empty,
    output logic                              q_pop,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [mcr_pkg::PIX_W-1:0]  pixel_x,
    output logic signed [mcr_pkg::PIX_W-1:0]  pixel_y,
    output logic        [mcr_pkg::OCT_W-1:0]  octant,
    output logic                              last_of_step,
    output logic                              circle_done
);
    import mcr_pkg::*;

    localparam logic [OCT_W-1:0] OCT_LAST = '1;

    job_t                    job_reg;
    logic                    busy_reg;
    logic [OCT_W-1:0]        oct_reg;
    logic                    out_valid_reg;
    logic signed [PIX_W-1:0] pixel_x_reg, pixel_y_reg;
    logic [OCT_W-1:0]        octant_reg;
    logic                    last_reg, done_reg;

    logic                    out_ready, emit, last;
    logic signed [PT_W-1:0]  first, second;
    logic signed [PIX_W-1:0] fx, fy, dx, dy;

    assign out_ready = !out_valid_reg || pop;
    assign emit      = busy_reg && out_ready;
    assign last      = (oct_reg == OCT_LAST);
    assign q_pop     = !q_empty && (!busy_reg || (emit && last));

    // octant bit 2 swaps a/b, bit 1 negates x, bit 0 negates y
    always_comb
    begin
        first  = oct_reg[2] ? job_reg.pb : job_reg.pa;
        second = oct_reg[2] ? job_reg.pa : job_reg.pb;
        fx     = PIX_W'(first);
        fy     = PIX_W'(second);
        dx     = oct_reg[1] ? -fx : fx;
        dy     = oct_reg[0] ? -fy : fy;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= q_rdata;
        if (emit)
        begin
            pixel_x_reg <= job_reg.scx + dx;
            pixel_y_reg <= job_reg.scy + dy;
            octant_reg  <= oct_reg;
            last_reg    <= last;
            done_reg    <= job_reg.done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            oct_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg <= 1'b1;
                oct_reg  <= '0;
            end
            else if (emit)
            begin
                oct_reg <= oct_reg + OCT_W'(1);
                if (last)
                    busy_reg <= 1'b0;
            end

            if (emit)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    assign empty        = !out_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign octant       = octant_reg;
    assign last_of_step = last_reg;
    assign circle_done  = done_reg;

endmodule

// ===== rtl/core/midpoint_circle_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer: midpoint circle walk with eight-way symmetry
// The first pixel of an item passes the job queue, the back end's job register
// and the single output register, which takes one pixel per cycle while it is
// free; the 2-entry job queue lets items enter on back-to-back cycles until full.
// Reset (async, active low): idle, no circle, job queue and output empty, origin = (300, 300).
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // item side
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  opcode,
    input  logic        [mcr_pkg::RAD_W-1:0]      radius,
    input  logic signed [mcr_pkg::CTR_W-1:0]      centre_x,
    input  logic signed [mcr_pkg::CTR_W-1:0]      centre_y,
    // result side
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [mcr_pkg::PIX_W-1:0]      pixel_x,
    output logic signed [mcr_pkg::PIX_W-1:0]      pixel_y,
    output logic        [mcr_pkg::OCT_W-1:0]      octant,
    output logic                                  last_of_step,
    output logic                                  circle_done,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [mcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [mcr_pkg::ORG_W-1:0]      cfg_data
);
    import mcr_pkg::*;

    // Origin registers. Writes are only expected while the block is idle, so
    // the front end samples them directly on a start transaction.
    logic [ORG_W-1:0] origin_x_reg;
    logic [ORG_W-1:0] origin_y_reg;

    // Front end to queue
    logic  q_push;
    job_t  q_wdata;
    logic  q_full;
    // Queue to back end
    job_t  q_rdata;
    logic  q_empty;
    logic  q_pop;
    logic  front_active;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= ORIGIN_RESET;
            origin_y_reg <= ORIGIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ORIGIN_X: origin_x_reg <= cfg_data;
                REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Intake stalls only when the job queue is full; a step transaction that
    // arrives with no circle in progress is taken and dropped.
    assign full = q_full;

    // Front end: classifies the transaction and runs one midpoint iteration
    // combinationally, producing the point to mirror plus the done flag.
    mcr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .opcode   (opcode),
        .radius   (radius),
        .centre_x (centre_x),
        .centre_y (centre_y),
        .origin_x (origin_x_reg),
        .origin_y (origin_y_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata),
        .active   (front_active)
    );

    // Short job queue decouples the iteration from the pixel output.
    mcr_job_fifo u_jobq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // Back end: eight mirrored pixels per job, one per cycle while the output
    // register is free; that register holds a result until it is popped.
    mcr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_rdata      (q_rdata),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .octant       (octant),
        .last_of_step (last_of_step),
        .circle_done  (circle_done)
    );

    // A start transaction always leaves a job behind for the back end.
    a_start_queues_job: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && opcode == OP_START) |=> !q_empty)
        else $error("start transaction did not queue a job");

    // The walk only ends right after queuing a job that carries the done flag.
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(front_active) |-> $past(q_push && q_wdata.done))
        else $error("circle ended without a final job");

    // Within a job the back end refills the output as soon as a pixel leaves.
    a_pixels_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_of_step) |=> !empty)
        else $error("gap inside the eight pixels of one job");

endmodule
